// ----- rtl/mcop_pkg.sv -----
package mcop_pkg;

    localparam int MAX_PES   = 64;
    localparam int MAX_ELEMS = 1024;
    localparam int PE_W      = $clog2(MAX_PES);
    localparam int NP_W      = PE_W + 1;
    localparam int ELEM_W    = $clog2(MAX_ELEMS);
    localparam int NE_W      = ELEM_W + 1;
    localparam int LOAD_W    = ELEM_W + 1;
    localparam int VOTE_W    = 32;

    localparam logic [1:0] OP_VOTE  = 2'd0;
    localparam logic [1:0] OP_FINAL = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] ST_QUERY = 2'd0;
    localparam logic [1:0] ST_FINAL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CFG_NUM_PES    = 2'd0;
    localparam logic [1:0] CFG_NUM_POINTS = 2'd1;
    localparam logic [1:0] CFG_NUM_ELEMS  = 2'd2;

    typedef enum logic [1:0] {
        K_VOTE  = 2'd0,
        K_FINAL = 2'd1,
        K_QUERY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ELEM_W-1:0]  element;
        logic [PE_W-1:0]    pe;
        logic               last;
    } t_job;

    // effective PE and element counts, already saturated
    typedef struct packed {
        logic [NP_W-1:0] np;
        logic [NE_W-1:0] ne;
    } t_cfg;

endpackage

// ----- rtl/mcop_in_if.sv -----
interface mcop_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [9:0]  element;
    logic [31:0] point_id;
    logic        last_point;

    modport source(output valid, output opcode, output element, output point_id,
                   output last_point, input ready);
    modport sink(input valid, input opcode, input element, input point_id,
                 input last_point, output ready);
endinterface

// ----- rtl/mcop_out_if.sv -----
interface mcop_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] out_element;
    logic [5:0] out_pe;
    logic [1:0] status;

    modport source(output valid, output out_element, output out_pe, output status,
                   input ready);
    modport sink(input valid, input out_element, input out_pe, input status,
                 output ready);
endinterface

// ----- rtl/mesh_chunk_owner_placement_core.sv -----
// Mesh chunk owner placement core.
// i_item takes words {opcode, element, point_id, last_point}; o_result gives
// words {out_element, out_pe, status}, valid/ready on both sides.
// Configuration: i_cfg_we with i_cfg_idx 0 num_pes, 1 num_points, 2 num_elements.
// Front: a vote word finds its PE by division, one quotient bit a cycle
// against the chunk size; finalize and query words pass straight to the push state.
// A two-entry queue sits between front and back.
// Back: a vote reads and writes back its PE's count (B_VRD, B_VWR), and B_VDEC
// stores the winner on an element's last point; a query answer goes through
// B_QRD and B_QOUT to the result register. Finalize walks the assignment table
// to count loads per element, then for each unused PE runs an argmax over the
// load table and searches the elements for one to take over. A write of num_pes
// or num_points recomputes the chunk size; the input stalls meanwhile.
// After reset the assignment table is cleared, one entry a cycle, through all 1024
// entries; i_item.ready stays low until then.
// A stalled receiver holds the result register; the back waits on its next
// result, the queue fills and then the input stalls.
module mesh_chunk_owner_placement_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcop_in_if.sink     i_item,
    mcop_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import mcop_pkg::*;

    t_job w_fjob, w_qjob;
    t_cfg w_cfg;
    logic w_push, w_pop, w_full, w_empty, w_clearing;

    mcop_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_hold     (w_clearing),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_fjob),
        .o_cfg      (w_cfg)
    );

    mcop_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fjob),
        .i_pop   (w_pop),
        .o_data  (w_qjob),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mcop_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_qjob),
        .i_empty    (w_empty),
        .i_cfg      (w_cfg),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_result   (o_result)
    );

endmodule

// ----- rtl/mcop_front.sv -----
module mcop_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mcop_in_if.sink           i_item,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_hold,
    input  logic              i_full,
    output logic              o_push,
    output mcop_pkg::t_job    o_job,
    output mcop_pkg::t_cfg    o_cfg
);
    import mcop_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate          r_state, n_state;
    logic [6:0]       r_num_pes;
    logic [31:0]      r_num_points;
    logic [10:0]      r_num_elems;
    logic [31:0]      r_chunk;
    logic             r_cbusy, r_cload;
    logic [4:0]       r_ccnt;
    logic [7:0]       r_crem;
    logic [31:0]      r_cquo;
    t_job             r_job;
    logic [31:0]      r_rem;
    logic [37:0]      r_dv;
    logic [PE_W-1:0]  r_q;
    logic [2:0]       r_step;
    logic             r_sat;

    logic [NP_W-1:0]  w_np;
    logic [NE_W-1:0]  w_ne;
    logic             w_accept;
    logic [7:0]       w_ctry;
    logic             w_cbit;
    logic             w_pbit;
    logic [PE_W-1:0]  w_qf;
    logic [PE_W-1:0]  w_pe;

    always_comb begin
        if (r_num_pes == 7'd0) begin
            w_np = NP_W'(1);
        end else if (r_num_pes > 7'(MAX_PES)) begin
            w_np = NP_W'(MAX_PES);
        end else begin
            w_np = NP_W'(r_num_pes);
        end
        if (r_num_elems == 11'd0) begin
            w_ne = NE_W'(1);
        end else if (r_num_elems > 11'(MAX_ELEMS)) begin
            w_ne = NE_W'(MAX_ELEMS);
        end else begin
            w_ne = NE_W'(r_num_elems);
        end
    end

    assign o_cfg.np = w_np;
    assign o_cfg.ne = w_ne;

    assign i_item.ready = (r_state == F_IDLE) && !r_cbusy && !i_hold;
    assign w_accept     = i_item.valid && i_item.ready;

    // chunk divider: one quotient bit per cycle
    assign w_ctry = {r_crem[6:0], r_cquo[31]};
    assign w_cbit = (w_ctry >= 8'(w_np));

    // point divider: quotient below MAX_PES, one bit per cycle
    assign w_pbit = ({6'd0, r_rem} >= r_dv);
    assign w_qf   = {r_q[PE_W-2:0], w_pbit};
    assign w_pe   = (r_sat || (NP_W'(w_qf) >= w_np)) ? PE_W'(w_np - NP_W'(1)) : w_qf;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    priority case (i_item.opcode)
                        OP_VOTE:  n_state = F_DIV;
                        OP_FINAL: n_state = F_PUSH;
                        OP_QUERY: n_state = F_PUSH;
                        default:  n_state = F_IDLE;
                    endcase
                end
            end
            F_DIV:  if (r_step == 3'd0) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_num_pes    <= 7'd1;
            r_num_points <= 32'd1;
            r_num_elems  <= 11'd1;
            r_chunk      <= 32'd1;
            r_cbusy      <= 1'b0;
            r_cload      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NUM_PES: begin
                        r_num_pes <= i_cfg_data[6:0];
                        r_cbusy   <= 1'b1;
                        r_cload   <= 1'b1;
                    end
                    CFG_NUM_POINTS: begin
                        r_num_points <= i_cfg_data;
                        r_cbusy      <= 1'b1;
                        r_cload      <= 1'b1;
                    end
                    CFG_NUM_ELEMS: r_num_elems <= i_cfg_data[10:0];
                    default: ;
                endcase
            end else if (r_cload) begin
                r_cload <= 1'b0;
            end else if (r_cbusy && r_ccnt == 5'd31) begin
                r_cbusy <= 1'b0;
                r_chunk <= (r_num_points > 32'(w_np)) ? {r_cquo[30:0], w_cbit} : 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cload) begin
            r_crem <= 8'd0;
            r_cquo <= r_num_points;
            r_ccnt <= 5'd0;
        end else if (r_cbusy) begin
            r_crem <= w_cbit ? (w_ctry - 8'(w_np)) : w_ctry;
            r_cquo <= {r_cquo[30:0], w_cbit};
            r_ccnt <= r_ccnt + 5'd1;
        end

        if (w_accept) begin
            r_job.element <= i_item.element;
            r_job.last    <= i_item.last_point;
            r_job.pe      <= '0;
            r_job.kind    <= (i_item.opcode == OP_FINAL) ? K_FINAL :
                             (i_item.opcode == OP_QUERY) ? K_QUERY : K_VOTE;
            r_rem  <= i_item.point_id;
            r_sat  <= ({6'd0, i_item.point_id} >= {r_chunk, 6'd0});
            r_dv   <= {1'b0, r_chunk, 5'd0};
            r_q    <= '0;
            r_step <= 3'(PE_W - 1);
        end else if (r_state == F_DIV) begin
            if (w_pbit) begin
                r_rem <= r_rem - r_dv[31:0];
            end
            r_dv   <= {1'b0, r_dv[37:1]};
            r_q    <= w_qf;
            r_step <= r_step - 3'd1;
            if (r_step == 3'd0) begin
                r_job.pe <= w_pe;
            end
        end
    end

endmodule

// ----- rtl/mcop_fifo.sv -----
module mcop_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcop_pkg::t_job i_data,
    input  logic           i_pop,
    output mcop_pkg::t_job o_data,
    output logic           o_full,
    output logic           o_empty
);
    import mcop_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ----- rtl/mcop_back.sv -----
module mcop_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mcop_pkg::t_job i_job,
    input  logic           i_empty,
    input  mcop_pkg::t_cfg i_cfg,
    output logic           o_pop,
    output logic           o_clearing,
    mcop_out_if.source     o_result
);
    import mcop_pkg::*;

    typedef enum logic [17:0] {
        B_CLEAR = 18'h00001,
        B_IDLE  = 18'h00002,
        B_VRD   = 18'h00004,
        B_VWR   = 18'h00008,
        B_VDEC  = 18'h00010,
        B_QRD   = 18'h00020,
        B_QOUT  = 18'h00040,
        B_FCRA  = 18'h00080,
        B_FCRL  = 18'h00100,
        B_FCWL  = 18'h00200,
        B_FPCHK = 18'h00400,
        B_FARD  = 18'h00800,
        B_FACMP = 18'h01000,
        B_FSRD  = 18'h02000,
        B_FSCMP = 18'h04000,
        B_FW1   = 18'h08000,
        B_FW2   = 18'h10000,
        B_FOUT  = 18'h20000
    } t_bstate;

    t_bstate            r_state, n_state;
    t_job               r_job;

    logic [PE_W-1:0]    r_assign_mem [MAX_ELEMS];
    logic [VOTE_W-1:0]  r_vote_mem [MAX_PES];
    logic [LOAD_W-1:0]  r_load_mem [MAX_PES];
    logic [PE_W-1:0]    r_a_rd;
    logic [VOTE_W-1:0]  r_v_rd;
    logic [LOAD_W-1:0]  r_l_rd;

    logic [MAX_PES-1:0] r_vvalid;
    logic [PE_W-1:0]    r_vbest;
    logic [VOTE_W-1:0]  r_vbcnt;

    logic [MAX_PES-1:0] r_lvalid;
    logic [MAX_PES-1:0] r_used;
    logic [ELEM_W-1:0]  r_e;
    logic [NP_W-1:0]    r_p;
    logic [PE_W-1:0]    r_q;
    logic [PE_W-1:0]    r_best;
    logic [LOAD_W-1:0]  r_bestl;

    logic               r_ov;
    logic [ELEM_W-1:0]  r_oelem;
    logic [PE_W-1:0]    r_ope;
    logic [1:0]         r_ost;

    logic [ELEM_W-1:0]  w_a_raddr;
    logic               w_a_we;
    logic [ELEM_W-1:0]  w_a_waddr;
    logic [PE_W-1:0]    w_a_wdata;
    logic [PE_W-1:0]    w_l_raddr;
    logic               w_l_we;
    logic [PE_W-1:0]    w_l_waddr;
    logic [LOAD_W-1:0]  w_l_wdata;
    logic [VOTE_W-1:0]  w_vcur, w_vnew;
    logic               w_vbetter;
    logic [LOAD_W-1:0]  w_lcur;
    logic               w_slot;
    logic               w_in_range;
    logic               w_e_last;

    assign w_slot     = !r_ov || o_result.ready;
    assign w_in_range = (NE_W'(r_job.element) < i_cfg.ne);
    assign w_e_last   = (NE_W'(r_e) == i_cfg.ne - NE_W'(1));
    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign o_clearing = (r_state == B_CLEAR);

    assign w_vcur    = r_vvalid[r_job.pe] ? r_v_rd : '0;
    assign w_vnew    = (&w_vcur) ? w_vcur : w_vcur + VOTE_W'(1);
    assign w_vbetter = (w_vnew > r_vbcnt) || ((w_vnew == r_vbcnt) && (r_job.pe < r_vbest));
    assign w_lcur    = r_lvalid[w_l_raddr] ? r_l_rd : '0;

    always_comb begin
        n_state   = r_state;
        w_a_raddr = r_e;
        w_a_we    = 1'b0;
        w_a_waddr = r_e;
        w_a_wdata = '0;
        w_l_raddr = r_q;
        w_l_we    = 1'b0;
        w_l_waddr = r_a_rd;
        w_l_wdata = '0;
        unique case (r_state)
            B_CLEAR: begin
                w_a_we = 1'b1;
                if (r_e == ELEM_W'(MAX_ELEMS - 1)) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_job.kind)
                        K_VOTE:  n_state = B_VRD;
                        K_QUERY: n_state = B_QRD;
                        K_FINAL: n_state = B_FCRA;
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_VRD: n_state = B_VWR;
            B_VWR: n_state = r_job.last ? B_VDEC : B_IDLE;
            B_VDEC: begin
                w_a_we    = w_in_range;
                w_a_waddr = r_job.element;
                w_a_wdata = r_vbest;
                n_state   = B_IDLE;
            end
            B_QRD: begin
                w_a_raddr = r_job.element;
                n_state   = B_QOUT;
            end
            B_QOUT: begin
                // keep the read address so the answer survives a stall
                w_a_raddr = r_job.element;
                if (w_slot) n_state = B_IDLE;
            end
            B_FCRA: n_state = B_FCRL;
            B_FCRL: begin
                w_l_raddr = r_a_rd;
                n_state   = B_FCWL;
            end
            B_FCWL: begin
                // count one more element on its PE
                w_l_raddr = r_a_rd;
                w_l_we    = 1'b1;
                w_l_waddr = r_a_rd;
                w_l_wdata = w_lcur + LOAD_W'(1);
                n_state   = w_e_last ? B_FPCHK : B_FCRA;
            end
            B_FPCHK: begin
                if (r_p == i_cfg.np) begin
                    n_state = B_FOUT;
                end else if (!r_used[0]) begin
                    n_state = B_FARD;
                end
            end
            B_FARD:  n_state = B_FACMP;
            B_FACMP: n_state = (r_q == PE_W'(MAX_PES - 1)) ? B_FSRD : B_FARD;
            B_FSRD:  n_state = B_FSCMP;
            B_FSCMP: begin
                if (r_a_rd == r_best) begin
                    w_a_we    = 1'b1;
                    w_a_wdata = r_p[PE_W-1:0];
                    n_state   = B_FW1;
                end else if (w_e_last) begin
                    n_state = B_FPCHK;
                end else begin
                    n_state = B_FSRD;
                end
            end
            B_FW1: begin
                w_l_we    = 1'b1;
                w_l_waddr = r_best;
                w_l_wdata = r_bestl - LOAD_W'(1);
                n_state   = B_FW2;
            end
            B_FW2: begin
                w_l_we    = 1'b1;
                w_l_waddr = r_p[PE_W-1:0];
                w_l_wdata = LOAD_W'(1);
                n_state   = B_FPCHK;
            end
            B_FOUT: if (w_slot) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_a_we) r_assign_mem[w_a_waddr] <= w_a_wdata;
        r_a_rd <= r_assign_mem[w_a_raddr];
        if (r_state == B_VWR) r_vote_mem[r_job.pe] <= w_vnew;
        r_v_rd <= r_vote_mem[r_job.pe];
        if (w_l_we) r_load_mem[w_l_waddr] <= w_l_wdata;
        r_l_rd <= r_load_mem[w_l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_e      <= '0;
            r_vvalid <= '0;
            r_vbest  <= '0;
            r_vbcnt  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == B_QOUT || r_state == B_FOUT) && w_slot) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: r_e <= r_e + ELEM_W'(1);
                B_VWR: begin
                    r_vvalid[r_job.pe] <= 1'b1;
                    if (w_vbetter) begin
                        r_vbest <= r_job.pe;
                        r_vbcnt <= w_vnew;
                    end
                end
                B_VDEC: begin
                    r_vvalid <= '0;
                    r_vbest  <= '0;
                    r_vbcnt  <= '0;
                end
                B_IDLE: if (!i_empty) r_e <= '0;
                B_FCWL: begin
                    if (w_e_last) begin
                        r_e <= '0;
                    end else begin
                        r_e <= r_e + ELEM_W'(1);
                    end
                end
                B_FPCHK: r_e <= '0;
                B_FSCMP: if (r_a_rd != r_best) r_e <= r_e + ELEM_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        unique case (r_state)
            B_IDLE: begin
                r_lvalid <= '0;
                r_used   <= '0;
                r_p      <= '0;
            end
            B_QOUT: begin
                if (w_slot) begin
                    r_oelem <= r_job.element;
                    r_ope   <= w_in_range ? r_a_rd : '0;
                    r_ost   <= w_in_range ? ST_QUERY : ST_RANGE;
                end
            end
            B_FOUT: begin
                if (w_slot) begin
                    r_oelem <= '0;
                    r_ope   <= '0;
                    r_ost   <= ST_FINAL;
                end
            end
            B_FCRL: r_used[r_a_rd] <= 1'b1;
            B_FCWL: r_lvalid[r_a_rd] <= 1'b1;
            B_FPCHK: begin
                if (r_p != i_cfg.np) begin
                    if (r_used[0]) begin
                        r_used <= {1'b0, r_used[MAX_PES-1:1]};
                        r_p    <= r_p + NP_W'(1);
                    end else begin
                        r_q     <= '0;
                        r_best  <= '0;
                        r_bestl <= '0;
                    end
                end
            end
            B_FACMP: begin
                if (w_lcur > r_bestl) begin
                    r_best  <= r_q;
                    r_bestl <= w_lcur;
                end
                r_q <= r_q + PE_W'(1);
            end
            B_FSCMP: begin
                if (r_a_rd != r_best && w_e_last) begin
                    r_used <= {1'b0, r_used[MAX_PES-1:1]};
                    r_p    <= r_p + NP_W'(1);
                end
            end
            B_FW2: begin
                r_lvalid[r_p[PE_W-1:0]] <= 1'b1;
                r_used <= {1'b0, r_used[MAX_PES-1:1]};
                r_p    <= r_p + NP_W'(1);
            end
            default: ;
        endcase
    end

    assign o_result.valid       = r_ov;
    assign o_result.out_element = r_oelem;
    assign o_result.out_pe      = r_ope;
    assign o_result.status      = r_ost;

endmodule

// ----- sim/mcop_placement_checker.sv -----
`timescale 1ns / 100ps

module mcop_placement_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcop_in_if          in_mon,
    mcop_out_if         out_mon,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);
    import mcop_pkg::*;

    typedef struct {
        logic [9:0] element;
        logic [5:0] pe;
        logic [1:0] status;
    } placement_t;

    placement_t     placement_q[$];
    logic [31:0]    votes[MAX_PES];
    logic [5:0]     owner[MAX_ELEMS];
    logic [6:0]     reg_pes;
    logic [31:0]    reg_points;
    logic [10:0]    reg_elems;
    logic [31:0]    chunk;
    int             errors = 0;

    assign o_pending = placement_q.size();
    assign o_errors  = errors;

    function automatic int pe_count();
        if (reg_pes < 1) return 1;
        if (reg_pes > MAX_PES) return MAX_PES;
        return int'(reg_pes);
    endfunction

    function automatic int elem_count();
        if (reg_elems < 1) return 1;
        if (reg_elems > MAX_ELEMS) return MAX_ELEMS;
        return int'(reg_elems);
    endfunction

    function automatic void refresh_chunk();
        logic [31:0] np;
        np = 32'(pe_count());
        chunk = (reg_points > np) ? reg_points / np : 32'd1;
        if (chunk == 0) chunk = 1;
    endfunction

    function automatic void clear_votes();
        foreach (votes[i]) votes[i] = '0;
    endfunction

    // idle PEs each take the first element of the currently most loaded PE
    function automatic void rebalance();
        bit used[MAX_PES];
        int unsigned load[MAX_PES];
        int np, ne, best;
        np = pe_count();
        ne = elem_count();
        foreach (used[i]) used[i] = 0;
        for (int e = 0; e < ne; e++) used[owner[e]] = 1;
        for (int p = 0; p < np; p++) begin
            if (used[p]) continue;
            foreach (load[i]) load[i] = 0;
            for (int e = 0; e < ne; e++) load[owner[e]]++;
            best = 0;
            for (int q = 1; q < MAX_PES; q++)
                if (load[q] > load[best]) best = q;
            for (int e = 0; e < ne; e++) begin
                if (owner[e] == best) begin
                    owner[e] = p[5:0];
                    break;
                end
            end
        end
    endfunction

    function automatic void predict_word(logic [1:0] op, logic [9:0] el,
                                         logic [31:0] pt, logic lst);
        logic [31:0] pe;
        int best;
        placement_t exp_w;
        case (op)
            OP_VOTE: begin
                pe = pt / chunk;
                if (pe >= pe_count()) pe = 32'(pe_count() - 1);
                if (votes[pe] != 32'hFFFF_FFFF) votes[pe]++;
                if (lst) begin
                    best = 0;
                    for (int q = 1; q < MAX_PES; q++)
                        if (votes[q] > votes[best]) best = q;
                    if (el < elem_count()) owner[el] = best[5:0];
                    clear_votes();
                end
            end
            OP_FINAL: begin
                rebalance();
                exp_w = '{element: '0, pe: '0, status: ST_FINAL};
                placement_q.push_back(exp_w);
            end
            OP_QUERY: begin
                if (el < elem_count())
                    exp_w = '{element: el, pe: owner[el], status: ST_QUERY};
                else
                    exp_w = '{element: el, pe: '0, status: ST_RANGE};
                placement_q.push_back(exp_w);
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what);
        $display("[%0t] placement mismatch: %s", $time, what);
        errors++;
    endtask

    initial begin
        clear_votes();
        foreach (owner[i]) owner[i] = '0;
        reg_pes = 1;
        reg_points = 1;
        reg_elems = 1;
        chunk = 1;
    end

    always @(posedge i_clk) begin
        placement_t exp_w;
        if (i_rst_n) begin
            if (out_mon.valid && out_mon.ready) begin
                if (placement_q.size() == 0) begin
                    report($sformatf("unexpected word el=%0d pe=%0d st=%0d",
                           out_mon.out_element, out_mon.out_pe, out_mon.status));
                end else begin
                    exp_w = placement_q.pop_front();
                    if (out_mon.out_element !== exp_w.element)
                        report($sformatf("out_element %0d, want %0d",
                               out_mon.out_element, exp_w.element));
                    if (out_mon.out_pe !== exp_w.pe)
                        report($sformatf("out_pe %0d, want %0d (el %0d)",
                               out_mon.out_pe, exp_w.pe, exp_w.element));
                    if (out_mon.status !== exp_w.status)
                        report($sformatf("status %0d, want %0d",
                               out_mon.status, exp_w.status));
                end
            end
            if (in_mon.valid && in_mon.ready)
                predict_word(in_mon.opcode, in_mon.element, in_mon.point_id,
                             in_mon.last_point);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_PES: begin
                        reg_pes = i_cfg_data[6:0];
                        refresh_chunk();
                    end
                    CFG_NUM_POINTS: begin
                        reg_points = i_cfg_data;
                        refresh_chunk();
                    end
                    CFG_NUM_ELEMS: reg_elems = i_cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- sim/mesh_chunk_owner_placement_core_tb.sv -----
`timescale 1ns / 100ps

module mesh_chunk_owner_placement_core_tb;
    import mcop_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    int          pending;
    int          errors;
    int          words_sent = 0;
    int          n_votes = 0;
    int          n_queries = 0;
    int          n_finals = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          idle_cycles = 0;
    logic [31:0] cur_points = 1;
    int          cur_elems = 1;

    mcop_in_if  item_if();
    mcop_out_if res_if();

    mesh_chunk_owner_placement_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    mcop_placement_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_mon     (item_if),
        .out_mon    (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // idle mix moves with progress: sender-light, receiver-light, then none
    always @(posedge i_clk) begin
        if (words_sent < 160) begin
            tx_idle <= 14;
            rx_idle <= 48;
        end else if (words_sent < 320) begin
            tx_idle <= 48;
            rx_idle <= 14;
        end else begin
            tx_idle <= 0;
            rx_idle <= 0;
        end
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                res_if.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1;
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("mesh_chunk_owner_placement_core_tb NOT OK");
            $finish;
        end
    end

    task automatic put_word(logic [1:0] op, logic [9:0] el, logic [31:0] pt,
                            logic lst);
        while ($urandom_range(99) < tx_idle) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.opcode     <= op;
        item_if.element    <= el;
        item_if.point_id   <= pt;
        item_if.last_point <= lst;
        do @(posedge i_clk); while (!item_if.ready);
        words_sent++;
        case (op)
            OP_VOTE:  n_votes++;
            OP_FINAL: n_finals++;
            OP_QUERY: n_queries++;
            default: ;
        endcase
    endtask

    // config only once drained; vote words give no result, so allow the tail
    task automatic write_regs(logic [6:0] pes, logic [31:0] points, logic [10:0] elems);
        item_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_NUM_PES; i_cfg_data <= {25'd0, pes};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_NUM_POINTS; i_cfg_data <= points;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_NUM_ELEMS; i_cfg_data <= {21'd0, elems};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (40) @(posedge i_clk);
        cur_points = points;
        cur_elems = (elems == 0) ? 1 : (elems > MAX_ELEMS) ? MAX_ELEMS : int'(elems);
    endtask

    function automatic logic [31:0] pick_point();
        if (cur_points > 1 && $urandom_range(99) < 75)
            return $urandom_range(cur_points - 1);
        return $urandom;
    endfunction

    function automatic logic [9:0] pick_element();
        if ($urandom_range(99) < 85) return 10'($urandom_range(cur_elems - 1));
        return 10'($urandom_range(1023));
    endfunction

    task automatic element_points(logic [9:0] el, int n);
        for (int k = 0; k < n; k++)
            put_word(OP_VOTE, el, pick_point(), k == n - 1);
    endtask

    task automatic random_words(int count, int fin_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            if (words_sent >= 320 && !hold_req) hold_req = 1;
            r = $urandom_range(99);
            if (r < 60)
                element_points(pick_element(), int'($urandom_range(1, 6)));
            else if (r < 85)
                put_word(OP_QUERY, pick_element(), $urandom, 1'($urandom_range(1)));
            else if (r < 85 + fin_pct)
                put_word(OP_FINAL, 10'($urandom), $urandom, 1'($urandom_range(1)));
            else if (r < 95)
                put_word(OP_VOTE, 10'($urandom), $urandom, 1'($urandom_range(1)));
            else
                put_word(OP_RSVD, 10'($urandom), $urandom, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_NUM_PES;
        i_cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.opcode = OP_VOTE;
        item_if.element = '0;
        item_if.point_id = '0;
        item_if.last_point = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // table clear after reset
        repeat (1100) @(posedge i_clk);

        write_regs(7'd4, 32'd100, 11'd8);
        put_word(OP_QUERY, 10'd0, 32'd0, 1'b0);
        put_word(OP_VOTE, 10'd0, 32'd0, 1'b1);
        put_word(OP_VOTE, 10'd1, 32'hFFFF_FFFF, 1'b1);      // saturates to top PE
        put_word(OP_VOTE, 10'd2, 32'd30, 1'b0);             // tie -> lower PE
        put_word(OP_VOTE, 10'd2, 32'd60, 1'b1);
        put_word(OP_VOTE, 10'd3, 32'd55, 1'b0);
        put_word(OP_VOTE, 10'd3, 32'd99, 1'b0);
        put_word(OP_VOTE, 10'd3, 32'd70, 1'b1);
        put_word(OP_VOTE, 10'd1023, 32'd75, 1'b1);          // decision dropped
        put_word(OP_QUERY, 10'd1, 32'd0, 1'b0);
        put_word(OP_QUERY, 10'd2, 32'd0, 1'b0);
        put_word(OP_QUERY, 10'd3, 32'd0, 1'b0);
        put_word(OP_QUERY, 10'd7, 32'hFFFF_FFFF, 1'b1);     // never decided
        put_word(OP_QUERY, 10'd8, 32'd0, 1'b0);
        put_word(OP_QUERY, 10'd1023, 32'd0, 1'b0);
        put_word(OP_RSVD, 10'd1023, 32'hFFFF_FFFF, 1'b1);
        put_word(OP_FINAL, 10'd0, 32'd0, 1'b0);
        for (int e = 0; e < 8; e++) put_word(OP_QUERY, 10'(e), 32'd0, 1'b0);
        random_words(20, 5);

        write_regs(7'd64, 32'hFFFF_FFFF, 11'd1024);
        random_words(24, 0);
        put_word(OP_FINAL, 10'd0, 32'd0, 1'b0);
        put_word(OP_QUERY, 10'd1023, 32'd0, 1'b0);

        write_regs(7'd0, 32'd5, 11'd0);
        random_words(16, 5);
        write_regs(7'd127, 32'd1000, 11'd2047);
        random_words(16, 0);
        write_regs(7'd8, 32'd3, 11'd20);
        random_words(32, 5);
        write_regs(7'd16, 32'd1600, 11'd64);
        random_words(40, 4);
        write_regs(7'd2, 32'd0, 11'd3);
        random_words(24, 5);

        item_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        $display("covered %0d words: %0d votes, %0d queries, %0d finalizes",
                 words_sent, n_votes, n_queries, n_finals);
        $display("seven register settings incl. saturated counts and chunk size 1");
        if (errors == 0)
            $display("mesh_chunk_owner_placement_core_tb OK");
        else
            $display("mesh_chunk_owner_placement_core_tb NOT OK");
        $finish;
    end

endmodule
